// File: hw/rtl/sha256_pkg.sv
// Shared types and constant tables of the SHA-256 block hash core.
`default_nettype none
package sha256_pkg;

  localparam int unsigned WORD_W = 32;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic       shift_in;
    logic       init_chain;
    logic       load_work;
    logic       round_en;
    logic [5:0] round_idx;
    logic       add_chain;
    logic [2:0] out_sel;
  } sha256_cmd_t;

  localparam word_t INIT_CHAIN [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage
`default_nettype wire

// File: hw/rtl/sha256_if.sv
// Valid/ready channel interfaces for message words and digest words.
`default_nettype none
interface sha256_msg_if;
  logic        valid;
  logic        ready;
  logic [31:0] msg_word;
  logic        first_of_message;
  logic        last_of_message;

  modport source (output valid, output msg_word, output first_of_message,
                  output last_of_message, input ready);
  modport sink (input valid, input msg_word, input first_of_message,
                input last_of_message, output ready);
endinterface

interface sha256_digest_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        digest_last;

  modport source (output valid, output digest_word, output digest_last, input ready);
  modport sink (input valid, input digest_word, input digest_last, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/sha256_block_hash_core.sv
// Top level of the SHA-256 block hash core.
// The core takes a padded message as 32-bit big-endian words, sixteen to a
// block, one word per cycle while ready is high. A word flagged as first of
// message reloads the initial chaining values and starts a new block. After
// the sixteenth word the core stops taking words while it runs the 64
// compression rounds, one round per cycle through a single round unit that
// also extends the schedule window, and then adds the working words into the
// chaining words. If the sixteenth word carried the last flag, the eight
// digest words follow, first word first, with the eighth marked last; words
// are taken again once the eighth digest word has been delivered.
`default_nettype none
module sha256_block_hash_core
  import sha256_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  sha256_msg_if.sink      msg,
  sha256_digest_if.source digest
);

  sha256_cmd_t cmd;

  sha256_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg.valid),
    .msg_first (msg.first_of_message),
    .msg_last  (msg.last_of_message),
    .msg_ready (msg.ready),
    .dig_valid (digest.valid),
    .dig_ready (digest.ready),
    .dig_last  (digest.digest_last),
    .cmd       (cmd)
  );

  sha256_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .msg_word    (msg.msg_word),
    .digest_word (digest.digest_word)
  );

endmodule
`default_nettype wire

// File: hw/rtl/sha256_datapath.sv
// Datapath: chaining words, working words, schedule window and one round unit.
`default_nettype none
module sha256_datapath
  import sha256_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire sha256_cmd_t cmd,
  input  wire word_t       msg_word,
  output word_t            digest_word
);

  word_t chain [8];
  word_t work [8];
  word_t win [16];

  word_t w_new;
  word_t shift_word;
  word_t t1;
  word_t t2;
  word_t bs0;
  word_t bs1;
  word_t ch;
  word_t maj;
  word_t sig0;
  word_t sig1;

  always_comb begin
    sig0 = {win[1][6:0], win[1][31:7]} ^ {win[1][17:0], win[1][31:18]}
         ^ (win[1] >> 3);
    sig1 = {win[14][16:0], win[14][31:17]} ^ {win[14][18:0], win[14][31:19]}
         ^ (win[14] >> 10);
    w_new = win[0] + sig0 + win[9] + sig1;
    shift_word = cmd.round_en ? w_new : msg_word;

    bs1 = {work[4][5:0], work[4][31:6]} ^ {work[4][10:0], work[4][31:11]}
        ^ {work[4][24:0], work[4][31:25]};
    ch = (work[4] & work[5]) ^ (~work[4] & work[6]);
    t1 = work[7] + bs1 + ch + ROUND_K[cmd.round_idx] + win[0];
    bs0 = {work[0][1:0], work[0][31:2]} ^ {work[0][12:0], work[0][31:13]}
        ^ {work[0][21:0], work[0][31:22]};
    maj = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
    t2 = bs0 + maj;
  end

  always_ff @(posedge clk) begin
    if (cmd.shift_in || cmd.round_en) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i+1];
      end
      win[15] <= shift_word;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      for (int i = 0; i < 8; i++) begin
        work[i] <= chain[i];
      end
    end else if (cmd.round_en) begin
      work[7] <= work[6];
      work[6] <= work[5];
      work[5] <= work[4];
      work[4] <= work[3] + t1;
      work[3] <= work[2];
      work[2] <= work[1];
      work[1] <= work[0];
      work[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.init_chain) begin
      for (int i = 0; i < 8; i++) begin
        chain[i] <= INIT_CHAIN[i];
      end
    end else if (cmd.add_chain) begin
      for (int i = 0; i < 8; i++) begin
        chain[i] <= chain[i] + work[i];
      end
    end
  end

  assign digest_word = chain[cmd.out_sel];

endmodule
`default_nettype wire

// File: hw/rtl/sha256_ctrl.sv
// Controller: word slot counter, round counter and digest output sequencing.
`default_nettype none
module sha256_ctrl
  import sha256_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  msg_valid,
  input  wire logic  msg_first,
  input  wire logic  msg_last,
  output logic       msg_ready,
  output logic       dig_valid,
  input  wire logic  dig_ready,
  output logic       dig_last,
  output sha256_cmd_t cmd
);

  localparam logic [3:0] LAST_SLOT  = 4'd15;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_OUT   = 3'd7;

  typedef enum logic [1:0] {
    S_LOAD,
    S_ROUND,
    S_ADD,
    S_EMIT
  } state_t;

  state_t     state;
  logic [3:0] pos;
  logic [5:0] rnd;
  logic [2:0] out_idx;
  logic       final_blk;

  logic       accept;
  logic [3:0] slot;
  logic       block_done;

  always_comb begin
    msg_ready  = (state == S_LOAD);
    accept     = msg_valid && msg_ready;
    slot       = msg_first ? 4'd0 : pos;
    block_done = (slot == LAST_SLOT);
    dig_valid  = (state == S_EMIT);
    dig_last   = (out_idx == LAST_OUT);

    cmd.shift_in   = accept;
    cmd.init_chain = accept && msg_first;
    cmd.load_work  = accept && block_done;
    cmd.round_en   = (state == S_ROUND);
    cmd.round_idx  = rnd;
    cmd.add_chain  = (state == S_ADD);
    cmd.out_sel    = out_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      pos       <= '0;
      rnd       <= '0;
      out_idx   <= '0;
      final_blk <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (accept) begin
            pos <= slot + 4'd1;
            if (block_done) begin
              final_blk <= msg_last;
              rnd       <= '0;
              state     <= S_ROUND;
            end
          end
        end
        S_ROUND: begin
          rnd <= rnd + 6'd1;
          if (rnd == LAST_ROUND) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          out_idx <= '0;
          state   <= final_blk ? S_EMIT : S_LOAD;
        end
        S_EMIT: begin
          if (dig_ready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == LAST_OUT) begin
              state <= S_LOAD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: sim/tb_top.sv
// Testbench for the SHA-256 block hash core: random and directed words checked against a predictor.
`timescale 1ns / 100ps
module tb_top
  import sha256_pkg::*;
();

  localparam int RANDOM_WORDS = 450;
  localparam int DRAIN_AT = 150;
  localparam int RX_HOLD_CYCLES = 600;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES = 200;

  localparam word_t IV_WORDS [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t K_TABLE [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    word_t word;
    logic  first;
    logic  last;
    logic  wait_drain;
  } msg_item_t;

  typedef struct packed {
    word_t word;
    logic  last;
  } digest_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sha256_msg_if    msg_ch ();
  sha256_digest_if dig_ch ();

  sha256_block_hash_core u_top (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_ch),
    .digest (dig_ch)
  );

  msg_item_t    word_queue [$];
  digest_beat_t digest_expect [$];

  word_t    chain_q [8];
  word_t    window_q [16];
  logic [3:0] slot_q;

  int total_items = 0;
  int sent_cnt = 0;
  int err_cnt = 0;
  int idle_cycles = 0;
  int rx_hold_left = 0;
  bit rx_hold_done = 1'b0;
  logic msg_taken = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t pick_word();
    int unsigned k;
    k = $urandom_range(0, 31);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return word_t'(1) << k;
      3: return ~(word_t'(1) << k);
      default: return $urandom();
    endcase
  endfunction

  function automatic int idle_phase();
    if (sent_cnt * 3 < total_items) return 0;
    if (sent_cnt * 3 < total_items * 2) return 1;
    return 2;
  endfunction

  task automatic compress_block();
    word_t w [64];
    word_t s [8];
    word_t x, y, t1, t2;
    int i;
    for (i = 0; i < 16; i++) w[i] = window_q[i];
    for (i = 16; i < 64; i++) begin
      x = w[i-15];
      y = w[i-2];
      w[i] = w[i-16] + (rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3)) + w[i-7] +
             (rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10));
    end
    for (i = 0; i < 8; i++) s[i] = chain_q[i];
    for (i = 0; i < 64; i++) begin
      t1 = s[7] + (rotr(s[4], 6) ^ rotr(s[4], 11) ^ rotr(s[4], 25)) +
           ((s[4] & s[5]) ^ (~s[4] & s[6])) + K_TABLE[i] + w[i];
      t2 = (rotr(s[0], 2) ^ rotr(s[0], 13) ^ rotr(s[0], 22)) +
           ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
      s[7] = s[6];
      s[6] = s[5];
      s[5] = s[4];
      s[4] = s[3] + t1;
      s[3] = s[2];
      s[2] = s[1];
      s[1] = s[0];
      s[0] = t1 + t2;
    end
    for (i = 0; i < 8; i++) chain_q[i] = chain_q[i] + s[i];
  endtask

  task automatic absorb_word(input msg_item_t it);
    digest_beat_t beat;
    int k;
    if (it.first) begin
      for (k = 0; k < 8; k++) chain_q[k] = IV_WORDS[k];
      slot_q = '0;
    end
    window_q[slot_q] = it.word;
    if (slot_q != 4'd15) begin
      slot_q = slot_q + 4'd1;
    end else begin
      slot_q = '0;
      compress_block();
      if (it.last) begin
        for (k = 0; k < 8; k++) begin
          beat.word = chain_q[k];
          beat.last = (k == 7);
          digest_expect.push_back(beat);
        end
      end
    end
  endtask

  always @(negedge clk) begin : drive_words
    msg_item_t nxt;
    int pct;
    if (!rst && (!msg_ch.valid || msg_taken)) begin
      pct = (idle_phase() == 0) ? 11 : (idle_phase() == 1) ? 46 : 0;
      if (word_queue.size() > 0 && $urandom_range(0, 99) >= pct &&
          !(word_queue[0].wait_drain && digest_expect.size() != 0)) begin
        nxt = word_queue.pop_front();
        msg_ch.valid            <= 1'b1;
        msg_ch.msg_word         <= nxt.word;
        msg_ch.first_of_message <= nxt.first;
        msg_ch.last_of_message  <= nxt.last;
      end else begin
        msg_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : drive_ready
    int pct;
    if (!rst) begin
      if (!rx_hold_done && idle_phase() == 2) begin
        rx_hold_done = 1'b1;
        rx_hold_left = RX_HOLD_CYCLES;
      end
      pct = (idle_phase() == 0) ? 46 : (idle_phase() == 1) ? 11 : 0;
      if (rx_hold_left > 0) begin
        rx_hold_left = rx_hold_left - 1;
        dig_ch.ready <= 1'b0;
      end else begin
        dig_ch.ready <= ($urandom_range(0, 99) >= pct);
      end
    end
  end

  always @(posedge clk) begin : watch_ports
    msg_item_t    got;
    digest_beat_t exp_beat;
    if (!rst) begin
      msg_taken <= msg_ch.valid && msg_ch.ready;
      if (dig_ch.valid && dig_ch.ready) begin
        if (digest_expect.size() == 0) begin
          $display("%0t: unexpected digest word, expected none, actual %h last %b",
                   $time, dig_ch.digest_word, dig_ch.digest_last);
          err_cnt++;
        end else begin
          exp_beat = digest_expect.pop_front();
          if (dig_ch.digest_word !== exp_beat.word) begin
            $display("%0t: digest_word mismatch, expected %h, actual %h",
                     $time, exp_beat.word, dig_ch.digest_word);
            err_cnt++;
          end
          if (dig_ch.digest_last !== exp_beat.last) begin
            $display("%0t: digest_last mismatch, expected %b, actual %b",
                     $time, exp_beat.last, dig_ch.digest_last);
            err_cnt++;
          end
        end
      end
      if (msg_ch.valid && msg_ch.ready) begin
        got.word       = msg_ch.msg_word;
        got.first      = msg_ch.first_of_message;
        got.last       = msg_ch.last_of_message;
        got.wait_drain = 1'b0;
        absorb_word(got);
        sent_cnt <= sent_cnt + 1;
      end
      if ((msg_ch.valid && msg_ch.ready) || (dig_ch.valid && dig_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin : run
    msg_item_t it;
    int k, b, j, nblk, len, kind;
    bit with_first, drain, drain_placed;
    msg_ch.valid            = 1'b0;
    msg_ch.msg_word         = '0;
    msg_ch.first_of_message = 1'b0;
    msg_ch.last_of_message  = 1'b0;
    dig_ch.ready            = 1'b0;
    for (k = 0; k < 8; k++) chain_q[k] = IV_WORDS[k];
    for (k = 0; k < 16; k++) window_q[k] = '0;
    slot_q = '0;
    drain_placed = 1'b0;

    // A partial block with a stray final flag, then dropped by a restart.
    it = '{word: 32'hffffffff, first: 1'b1, last: 1'b0, wait_drain: 1'b0};
    word_queue.push_back(it);
    it = '{word: 32'h00000000, first: 1'b0, last: 1'b1, wait_drain: 1'b0};
    word_queue.push_back(it);
    it = '{word: 32'h80000000, first: 1'b0, last: 1'b0, wait_drain: 1'b0};
    word_queue.push_back(it);
    it = '{word: 32'h00000001, first: 1'b0, last: 1'b1, wait_drain: 1'b0};
    word_queue.push_back(it);
    // The padded three-byte message "abc" as a single block.
    for (j = 0; j < 16; j++) begin
      it.word = (j == 0) ? 32'h61626380 : (j == 15) ? 32'h00000018 : 32'h0;
      it.first = (j == 0);
      it.last = (j == 15);
      it.wait_drain = 1'b0;
      word_queue.push_back(it);
    end

    while (word_queue.size() < 20 + RANDOM_WORDS) begin
      kind = $urandom_range(0, 9);
      drain = !drain_placed && word_queue.size() >= DRAIN_AT;
      if (drain) drain_placed = 1'b1;
      if (kind <= 6) begin
        nblk = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
        with_first = ($urandom_range(0, 7) != 0);
        for (b = 0; b < nblk; b++) begin
          for (j = 0; j < 16; j++) begin
            it.word = pick_word();
            it.first = with_first && b == 0 && j == 0;
            it.last = (j == 15) ? (b == nblk - 1) : ($urandom_range(0, 15) == 0);
            it.wait_drain = drain && b == 0 && j == 0;
            word_queue.push_back(it);
          end
        end
      end else begin
        len = (kind == 9) ? $urandom_range(1, 15) : $urandom_range(1, 20);
        for (j = 0; j < len; j++) begin
          it.word = pick_word();
          it.first = (kind == 9) ? (j == 0) : ($urandom_range(0, 5) == 0);
          it.last = ($urandom_range(0, 3) == 0);
          it.wait_drain = drain && j == 0;
          word_queue.push_back(it);
        end
      end
    end
    total_items = word_queue.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (sent_cnt < total_items || digest_expect.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/sha256_pkg.sv
hw/rtl/sha256_if.sv
hw/rtl/sha256_datapath.sv
hw/rtl/sha256_ctrl.sv
hw/rtl/sha256_block_hash_core.sv
sim/tb_top.sv
